/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sorted insert table.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, idle while the active-low reset is low.
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check a property on the block clock and reset.
`define ASSERT_STD(label, prop) \
  `ASSERT_AT(label, clk_i, rst_ni, prop)

`endif

/* hdl/sia_pkg.sv */
// ---------------------------------------------------------------------------
// sia_pkg
// Types and constants shared by the sorted insert table modules.
// ---------------------------------------------------------------------------
package sia_pkg;

  // Defaults for the top level parameters
  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int OPC_W      = 2;
  localparam int IDX_W      = 6;
  localparam int CNT_OUT_W  = 7;
  localparam int CAP_REG_W  = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Register reset values
  localparam logic [CAP_REG_W-1:0] CAP_RESET = 7'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INS_EN   = 1'b1;

  // Operation codes
  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_DISABLED = 2'd3
  } status_e;

  // Configuration seen by the engine
  typedef struct packed {
    logic [CAP_REG_W-1:0] capacity;
    logic                 insert_enabled;
  } cfg_t;

  // Status part of a result
  typedef struct packed {
    status_e              status;
    logic [CNT_OUT_W-1:0] entry_count;
  } res_meta_t;

endpackage

/* hdl/sia_in_if.sv */
// ---------------------------------------------------------------------------
// sia_in_if
// Request channel: valid/ready handshake with opcode, value and index.
// ---------------------------------------------------------------------------
interface sia_in_if
  import sia_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();

  logic                   valid;
  logic                   ready;
  logic [OPC_W-1:0]       opcode;
  logic [VALUE_WIDTH-1:0] item_value;
  logic [IDX_W-1:0]       entry_index;

  modport source (output valid, output opcode, output item_value, output entry_index,
                  input ready);
  modport sink (input valid, input opcode, input item_value, input entry_index,
                output ready);

endinterface

/* hdl/sia_out_if.sv */
// ---------------------------------------------------------------------------
// sia_out_if
// Result channel: valid/ready handshake with read value, status and count.
// ---------------------------------------------------------------------------
interface sia_out_if
  import sia_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] read_value;
  logic [1:0]             status;
  logic [CNT_OUT_W-1:0]   entry_count;

  modport source (output valid, output read_value, output status, output entry_count,
                  input ready);
  modport sink (input valid, input read_value, input status, input entry_count,
                output ready);

endinterface

/* hdl/sia_engine.sv */
// ---------------------------------------------------------------------------
// sia_engine
// Sequencer around the entry memory: scans and shifts one entry per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sia_engine
  import sia_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  sia_in_if.sink                 in_s,
  input  cfg_t                   cfg_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output logic [VALUE_WIDTH-1:0] res_value_o,
  output res_meta_t              res_meta_o
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int MW  = (CW > CAP_REG_W) ? CW : CAP_REG_W;
  localparam int WW  = ((MW > IDX_W) ? MW : IDX_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PUT,
    S_REM,
    S_RD,
    S_DONE
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          k_q, k_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [VALUE_WIDTH-1:0] rv_q, rv_d;
  status_e                status_q, status_d;

  logic [VALUE_WIDTH-1:0] mem_q [CAPACITY];
  logic [VALUE_WIDTH-1:0] rdata_q;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [AW-1:0]          raddr;

  logic [WW-1:0]          count_x;
  logic [WW-1:0]          cap_x;
  logic [WW-1:0]          limit_x;
  logic [WW-1:0]          idx_x;

  // Compare operands at a common width
  assign count_x = WW'(count_q);
  assign cap_x   = WW'(cfg_i.capacity);
  assign limit_x = (cap_x > WW'(CAPACITY)) ? WW'(CAPACITY) : cap_x;
  assign idx_x   = WW'(in_s.entry_index);

  // Sequence each operation; insert scans down from the top, remove walks up
  // from the index, moving entries down. The write trails the read by two
  // entries, so mid-scan the same entry is never read and written in one cycle.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    k_d      = k_q;
    val_d    = val_q;
    rv_d     = rv_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = k_q + AW'(1);
    wdata    = rdata_q;
    raddr    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_s.valid) begin
          val_d    = in_s.item_value;
          rv_d     = '0;
          status_d = ST_OK;
          state_d  = S_DONE;
          case (in_s.opcode)
            OP_INSERT: begin
              if (!cfg_i.insert_enabled) begin
                status_d = ST_DISABLED;
              end else if (count_x >= limit_x) begin
                status_d = ST_FULL;
              end else if (count_q == '0) begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = in_s.item_value;
                count_d = count_q + CW'(1);
              end else begin
                k_d     = AW'(count_q - CW'(1));
                raddr   = k_d;
                state_d = S_INS;
              end
            end
            OP_REMOVE: begin
              if (idx_x >= count_x) begin
                status_d = ST_RANGE;
              end else if (idx_x + WW'(1) == count_x) begin
                count_d = count_q - CW'(1);
              end else begin
                k_d     = AW'(in_s.entry_index);
                raddr   = k_d + AW'(1);
                state_d = S_REM;
              end
            end
            OP_READ: begin
              if (idx_x >= count_x) begin
                status_d = ST_RANGE;
              end else begin
                raddr   = AW'(in_s.entry_index);
                state_d = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        we = 1'b1;
        if (rdata_q >= val_q) begin
          // Shift this entry up and keep scanning down
          waddr = k_q + AW'(1);
          wdata = rdata_q;
          if (k_q == '0) begin
            state_d = S_PUT;
          end else begin
            k_d   = k_q - AW'(1);
            raddr = k_d;
          end
        end else begin
          // Drop the new value just above the first smaller entry
          waddr   = k_q + AW'(1);
          wdata   = val_q;
          count_d = count_q + CW'(1);
          state_d = S_DONE;
        end
      end
      S_PUT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = val_q;
        count_d = count_q + CW'(1);
        state_d = S_DONE;
      end
      S_REM: begin
        we    = 1'b1;
        waddr = k_q;
        wdata = rdata_q;
        if (WW'(k_q) + WW'(2) == count_x) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          k_d   = k_q + AW'(1);
          raddr = k_d + AW'(1);
        end
      end
      S_RD: begin
        rv_d    = rdata_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, count and the pending result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      k_q      <= '0;
      val_q    <= '0;
      rv_q     <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      k_q      <= k_d;
      val_q    <= val_d;
      rv_q     <= rv_d;
      status_q <= status_d;
    end
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign in_s.ready             = (state_q == S_IDLE);
  assign res_valid_o            = (state_q == S_DONE);
  assign res_value_o            = rv_q;
  assign res_meta_o.status      = status_q;
  assign res_meta_o.entry_count = CNT_OUT_W'(count_q);

  `ASSERT_STD(a_count_bound, count_q <= CW'(CAPACITY))
  `ASSERT_STD(a_put_grows, (state_q == S_PUT) |=> (count_q == $past(count_q) + CW'(1)))
  `ASSERT_STD(a_result_holds, (state_q == S_DONE && !res_ready_i) |=>
              (state_q == S_DONE && $stable(rv_q) && $stable(status_q)))
  `ASSERT_STD(a_no_overlap, (we && state_d == state_q &&
              (state_q == S_INS || state_q == S_REM)) |-> (waddr != raddr))

endmodule

/* hdl/sorted_insert_array_core.sv */
// ---------------------------------------------------------------------------
// sorted_insert_array_core
// Sorted table of unsigned values with insert, remove at index and read.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake      Payload
//  in_s     in   valid/ready    opcode, item_value, entry_index
//  out_s    out  valid/ready    read_value, status, entry_count
//  cfg      in   cfg_we_i only  cfg_idx_i, cfg_wdata_i
//
//  Rejected operations and opcode 3 go straight to the result; a read
//  passes the read state. Insert into an empty table writes at once;
//  else insert scans down, shifting up each entry not less than the
//  value, then writes the value. Remove shifts each entry above the index
//  down. Memory moves one entry per cycle via its single read and write port.
//  Reset clears the count and control registers; the memory is not cleared.
//  A stalled result waits in the output register while the next item runs.
// ---------------------------------------------------------------------------
module sorted_insert_array_core
  import sia_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sia_in_if.sink                in_s,
  sia_out_if.source             out_s,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t                   cfg_q;
  logic                   res_valid;
  logic                   res_ready;
  logic [VALUE_WIDTH-1:0] res_value;
  res_meta_t              res_meta;

  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_value_q;
  res_meta_t              out_meta_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity       <= CAP_RESET;
      cfg_q.insert_enabled <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAPACITY: cfg_q.capacity       <= CAP_REG_W'(cfg_wdata_i);
        CFG_INS_EN:   cfg_q.insert_enabled <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  sia_engine #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_s),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_value_o (res_value),
    .res_meta_o  (res_meta)
  );

  // Take a result when the output register is empty or being drained
  assign res_ready = !out_valid_q || out_s.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_value_q <= res_value;
      out_meta_q  <= res_meta;
    end
  end

  assign out_s.valid       = out_valid_q;
  assign out_s.read_value  = out_value_q;
  assign out_s.status      = out_meta_q.status;
  assign out_s.entry_count = out_meta_q.entry_count;

endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted insert table. A directed table covers
// the empty, full, disabled and out-of-range cases, then random phases
// sweep the capacity and insert enable settings. An in-bench table model
// predicts each result not typed in the table; a scoreboard compares them in order.
// ---------------------------------------------------------------------------
module tb_top;
  import sia_pkg::*;

  localparam logic [OPC_W-1:0] OP_NOP = 2'd3;  // unused opcode, no operation

  localparam int SETTLE_CYCLES = 4;        // quiet cycles before a register write
  localparam int TAIL_CYCLES   = 80;       // longer than the slowest insert
  localparam int IDLE_PCT      = 38;
  localparam int DIR_N         = 26;
  localparam int PHASE_N       = 6;
  localparam longint TIMEOUT_TU = 10_000_000;

  // One predicted or observed result
  typedef struct packed {
    logic [VALUE_WIDTH_DEF-1:0] read_value;
    status_e                    status;
    logic [CNT_OUT_W-1:0]       entry_count;
  } table_res_t;

  // One row of the directed table: a register write or an item
  typedef struct packed {
    bit                         is_cfg;
    logic [CFG_IDX_W-1:0]       reg_idx;
    logic [CFG_DATA_W-1:0]      reg_val;
    logic [OPC_W-1:0]           op;
    logic [VALUE_WIDTH_DEF-1:0] val;
    logic [IDX_W-1:0]           idx;
    bit                         has_exp;
    table_res_t                 exp_res;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sia_in_if  #(.VALUE_WIDTH(VALUE_WIDTH_DEF)) in_if ();
  sia_out_if #(.VALUE_WIDTH(VALUE_WIDTH_DEF)) out_if ();

  sorted_insert_array_core #(
    .CAPACITY   (CAPACITY_DEF),
    .VALUE_WIDTH(VALUE_WIDTH_DEF)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_if),
    .out_s      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Table model state
  logic [VALUE_WIDTH_DEF-1:0] tbl_entries [CAPACITY_DEF];
  int unsigned                tbl_count    = 0;
  int unsigned                tbl_capacity = 32'(CAP_RESET);
  bit                         tbl_ins_en   = 1'b1;

  table_res_t  pending_results [$];
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  bit          burst_mode   = 1'b0;
  dir_row_t    dir_rows [DIR_N];

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Apply one operation to the table model and return its result
  function automatic table_res_t apply_table_op(input logic [OPC_W-1:0] op,
                                                input logic [VALUE_WIDTH_DEF-1:0] val,
                                                input logic [IDX_W-1:0] idx);
    table_res_t  res;
    int unsigned limit;
    int unsigned pos;
    int unsigned k;
    res.read_value = '0;
    res.status     = ST_OK;
    limit = (tbl_capacity > CAPACITY_DEF) ? CAPACITY_DEF : tbl_capacity;
    case (op)
      OP_INSERT: begin
        if (!tbl_ins_en) begin
          res.status = ST_DISABLED;
        end else if (tbl_count >= limit) begin
          res.status = ST_FULL;
        end else begin
          // Go ahead of equal entries, shift the rest up
          pos = 0;
          while (pos < tbl_count && tbl_entries[pos] < val) pos++;
          for (k = tbl_count; k > pos; k--) tbl_entries[k] = tbl_entries[k-1];
          tbl_entries[pos] = val;
          tbl_count++;
        end
      end
      OP_REMOVE: begin
        if (idx >= tbl_count) begin
          res.status = ST_RANGE;
        end else begin
          for (k = 32'(idx); k + 1 < tbl_count; k++) tbl_entries[k] = tbl_entries[k+1];
          tbl_count--;
        end
      end
      OP_READ: begin
        if (idx < tbl_count) begin
          res.read_value = tbl_entries[idx];
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    res.entry_count = tbl_count[CNT_OUT_W-1:0];
    return res;
  endfunction

  // Directed table row builders
  function automatic dir_row_t op_row(input logic [OPC_W-1:0] op,
                                      input logic [VALUE_WIDTH_DEF-1:0] val,
                                      input logic [IDX_W-1:0] idx);
    dir_row_t row;
    row         = '0;
    row.op      = op;
    row.val     = val;
    row.idx     = idx;
    return row;
  endfunction

  function automatic dir_row_t chk_row(input logic [OPC_W-1:0] op,
                                       input logic [VALUE_WIDTH_DEF-1:0] val,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [VALUE_WIDTH_DEF-1:0] rv,
                                       input status_e st,
                                       input logic [CNT_OUT_W-1:0] cnt);
    dir_row_t row;
    row         = op_row(op, val, idx);
    row.has_exp = 1'b1;
    row.exp_res = '{read_value: rv, status: st, entry_count: cnt};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] ridx,
                                       input logic [CFG_DATA_W-1:0] rval);
    dir_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.reg_idx = ridx;
    row.reg_val = rval;
    return row;
  endfunction

  // Send one item with random idle cycles ahead; predict it once accepted
  task automatic issue_op(input logic [OPC_W-1:0] op,
                          input logic [VALUE_WIDTH_DEF-1:0] val,
                          input logic [IDX_W-1:0] idx,
                          input bit typed,
                          input table_res_t typed_res);
    table_res_t model_res;
    while (!burst_mode && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.item_value  <= val;
    in_if.entry_index <= idx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    model_res = apply_table_op(op, val, idx);
    pending_results.push_back(typed ? typed_res : model_res);
    items_sent++;
  endtask

  // Wait until the table is idle, then write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] ridx,
                           input logic [CFG_DATA_W-1:0] rval);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= ridx;
    cfg_wdata <= rval;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (ridx == CFG_CAPACITY) begin
      tbl_capacity = 32'(rval);
    end else begin
      tbl_ins_en = rval[0];
    end
  endtask

  // Result side: random back-pressure, none during a burst
  always @(posedge clk_i) begin
    out_if.ready <= burst_mode || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Scoreboard: compare each result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    table_res_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      status_seen[out_if.status]++;
      if (pending_results.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected result: rv=%h st=%0d cnt=%0d",
                   out_if.read_value, out_if.status, out_if.entry_count);
        end
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_if.read_value !== exp_res.read_value ||
            out_if.status !== exp_res.status ||
            out_if.entry_count !== exp_res.entry_count) begin
          if (fail_count < 10) begin
            $display("result %0d mismatch: exp rv=%h st=%0d cnt=%0d, got rv=%h st=%0d cnt=%0d",
                     results_seen, exp_res.read_value, exp_res.status,
                     exp_res.entry_count, out_if.read_value, out_if.status,
                     out_if.entry_count);
          end
          fail_count++;
        end
      end
    end
  end

  // Hard stop on a hang
  initial begin
    #(TIMEOUT_TU);
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAILURE");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int unsigned ph_cap    [PHASE_N];
    bit          ph_en     [PHASE_N];
    int unsigned ph_len    [PHASE_N];
    int unsigned ph_ins    [PHASE_N];
    int unsigned ph;
    int unsigned n;
    int unsigned pick;
    logic [OPC_W-1:0]           op;
    logic [VALUE_WIDTH_DEF-1:0] val;
    logic [IDX_W-1:0]           idx;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.opcode      = OP_INSERT;
    in_if.item_value  = '0;
    in_if.entry_index = '0;
    out_if.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_CAPACITY;
    cfg_wdata         = '0;

    // Directed rows: typed where the answer is plain, else the model decides
    dir_rows = '{
      chk_row(OP_READ,   32'h0,         6'd0,  32'h0, ST_RANGE, 7'd0),
      chk_row(OP_REMOVE, 32'h0,         6'd0,  32'h0, ST_RANGE, 7'd0),
      chk_row(OP_NOP,    32'hFFFF_FFFF, 6'd63, 32'h0, ST_OK,    7'd0),
      chk_row(OP_INSERT, 32'hFFFF_FFFF, 6'd0,  32'h0, ST_OK,    7'd1),
      chk_row(OP_INSERT, 32'h0,         6'd0,  32'h0, ST_OK,    7'd2),
      chk_row(OP_INSERT, 32'h0,         6'd63, 32'h0, ST_OK,    7'd3),
      op_row (OP_INSERT, 32'h8000_0000, 6'd0),
      chk_row(OP_READ,   32'h0,         6'd3,  32'hFFFF_FFFF, ST_OK, 7'd4),
      chk_row(OP_READ,   32'h0,         6'd63, 32'h0, ST_RANGE, 7'd4),
      op_row (OP_REMOVE, 32'h0,         6'd0),
      op_row (OP_REMOVE, 32'h0,         6'd2),
      cfg_row(CFG_INS_EN,   7'd0),
      chk_row(OP_INSERT, 32'h5,         6'd0,  32'h0, ST_DISABLED, 7'd2),
      cfg_row(CFG_INS_EN,   7'd1),
      cfg_row(CFG_CAPACITY, 7'd1),
      chk_row(OP_INSERT, 32'h7,         6'd0,  32'h0, ST_FULL,  7'd2),
      op_row (OP_READ,   32'h0,         6'd1),
      op_row (OP_REMOVE, 32'h0,         6'd0),
      chk_row(OP_INSERT, 32'h3,         6'd0,  32'h0, ST_FULL,  7'd1),
      cfg_row(CFG_CAPACITY, 7'd0),
      op_row (OP_REMOVE, 32'h0,         6'd0),
      chk_row(OP_INSERT, 32'h9,         6'd0,  32'h0, ST_FULL,  7'd0),
      cfg_row(CFG_CAPACITY, 7'd127),
      op_row (OP_INSERT, 32'h5555_AAAA, 6'd0),
      op_row (OP_READ,   32'h0,         6'd0),
      cfg_row(CFG_CAPACITY, 7'd64)
    };

    // Random phases: capacity, insert enable, length, insert share in percent
    ph_cap = '{64, 127, $urandom_range(2, 63), 0, 64, 64};
    ph_en  = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    ph_len = '{200, 60, 150, 30, 30, 230};
    ph_ins = '{70, 55, 45, 40, 50, 30};

    // Hold reset, release on a clock edge
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (n = 0; n < DIR_N; n++) begin
      if (dir_rows[n].is_cfg) begin
        write_reg(dir_rows[n].reg_idx, dir_rows[n].reg_val);
      end else begin
        issue_op(dir_rows[n].op, dir_rows[n].val, dir_rows[n].idx,
                 dir_rows[n].has_exp, dir_rows[n].exp_res);
      end
    end

    // Random phases
    for (ph = 0; ph < PHASE_N; ph++) begin
      write_reg(CFG_CAPACITY, ph_cap[ph][CFG_DATA_W-1:0]);
      write_reg(CFG_INS_EN, {{(CFG_DATA_W-1){1'b0}}, ph_en[ph]});
      for (n = 0; n < ph_len[ph]; n++) begin
        burst_mode = (items_sent >= 300 && items_sent < 420);

        // Pick the operation
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          op = OP_NOP;
        end else if (pick < 4 + ph_ins[ph]) begin
          op = OP_INSERT;
        end else if (pick[0]) begin
          op = OP_REMOVE;
        end else begin
          op = OP_READ;
        end

        // Favor extremes and small values so equal entries show up
        case ($urandom_range(0, 9))
          0:       val = '0;
          1:       val = '1;
          2, 3:    val = $urandom_range(0, 15);
          default: val = $urandom;
        endcase

        // Mostly a live index, sometimes anything
        if (tbl_count == 0 || $urandom_range(0, 9) == 0) begin
          idx = IDX_W'($urandom_range(0, 63));
        end else begin
          idx = IDX_W'($urandom_range(0, tbl_count - 1));
        end

        issue_op(op, val, idx, 1'b0, '0);
      end
    end
    burst_mode = 1'b0;

    // Drain, then watch for strays
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) fail_count++;

    $display("%0d items, %0d results: ok %0d, full %0d, range %0d, disabled %0d",
             items_sent, results_seen, status_seen[ST_OK], status_seen[ST_FULL],
             status_seen[ST_RANGE], status_seen[ST_DISABLED]);
    $display("capacity swept over 0, 1, mid, 64 and 127; insert enable toggled");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failures", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
